// ===== src/gtc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtc_pkg
// shared constants and controller/datapath interface types for the tree check
// ----------------------------------------------------------------------------
package gtc_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 1024;

  // fixed field widths
  localparam int NODE_W = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index of node_count
  localparam logic [0:0] REG_NODE_COUNT = 1'b0;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1;

  // request codes
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic clr;        // clear one visited entry
    logic sweep_rst;  // restart clear sweep
    logic start;      // latch initial bad flag, rewind edge index
    logic chk;        // range check of the current stored edge
    logic idx_inc;    // step to next stored edge
    logic seed;       // mark node 0 and start the first pass
    logic relax;      // propagate visited marks across the current edge
    logic pass_rst;   // rewind for another pass
    logic finish;     // load result, clear graph
  } gtc_cmd_t;

  typedef struct packed {
    logic fin_acc;
    logic cnt_zero;
    logic idx_last;
    logic sweep_last;
    logic bad;
    logic cnt_ok;
    logic changed;
    logic out_free;
  } gtc_sts_t;

endpackage

// ===== src/gtc_ram.sv =====
// ----------------------------------------------------------------------------
// gtc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gtc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/gtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtc_ctrl
// sequencer for clear sweep, endpoint check pass and reachability passes
// ----------------------------------------------------------------------------
module gtc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  gtc_pkg::gtc_sts_t sts,
  output gtc_pkg::gtc_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHK_RD, ST_CHK_EV, ST_SEL, ST_SEED,
    ST_RX_RD, ST_RX_VR, ST_RX_EV, ST_PASS_END, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (sts.fin_acc) begin
          cmd.start = 1'b1;
          state_nxt = sts.cnt_zero ? ST_SEL : ST_CHK_RD;
        end
      end
      ST_CHK_RD: state_nxt = ST_CHK_EV;
      ST_CHK_EV: begin
        cmd.chk = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt = sts.idx_last ? ST_SEL : ST_CHK_RD;
      end
      ST_SEL: state_nxt = (!sts.bad && sts.cnt_ok) ? ST_SEED : ST_DONE;
      ST_SEED: begin
        cmd.seed = 1'b1;
        state_nxt = sts.cnt_zero ? ST_DONE : ST_RX_RD;
      end
      ST_RX_RD: state_nxt = ST_RX_VR;
      ST_RX_VR: state_nxt = ST_RX_EV;
      ST_RX_EV: begin
        cmd.relax = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt = sts.idx_last ? ST_PASS_END : ST_RX_RD;
      end
      ST_PASS_END: begin
        if (sts.changed) begin
          cmd.pass_rst = 1'b1;
          state_nxt = ST_RX_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          cmd.sweep_rst = 1'b1;
          state_nxt = ST_CLEAR;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== src/gtc_dp.sv =====
// ----------------------------------------------------------------------------
// gtc_dp
// edge store, visited marks, counters and result register
// ----------------------------------------------------------------------------
module gtc_dp #(
  parameter int MAX_NODES = gtc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = gtc_pkg::DEF_MAX_EDGES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       add_acc,
  input  logic                       fin_acc,
  input  logic [gtc_pkg::NODE_W-1:0] end_a,
  input  logic [gtc_pkg::NODE_W-1:0] end_b,
  input  logic [gtc_pkg::NODE_W-1:0] node_count,
  input  gtc_pkg::gtc_cmd_t          cmd,
  input  logic                       out_stall,
  output gtc_pkg::gtc_sts_t          sts,
  output logic                       out_valid,
  output logic                       out_is_tree,
  output logic                       out_bad_input
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int VW  = $clog2(MAX_NODES + 1);

  logic [EW-1:0]    edge_count_r;
  logic             error_r;
  logic [EAW-1:0]   idx_r;
  logic [NAW-1:0]   sweep_r;
  logic [VW-1:0]    vcnt_r;
  logic             bad_r, changed_r;
  logic             out_valid_r, out_tree_r, out_bad_r;

  logic [2*NAW-1:0] edge_q;
  logic [NAW-1:0]   ea, eb;
  logic             va, vb;
  logic [31:0]      a32, b32, n32;
  logic             add_bad, add_full, add_we;
  logic             vis_we, vis_wd, mark;
  logic [NAW-1:0]   vis_wa;

  assign a32 = 32'(end_a);
  assign b32 = 32'(end_b);
  assign n32 = 32'(node_count);
  assign add_bad = (a32 == 0) || (a32 > n32) || (a32 > MAX_NODES) ||
                   (b32 == 0) || (b32 > n32) || (b32 > MAX_NODES);
  assign add_full = (32'(edge_count_r) >= MAX_EDGES);
  assign add_we = add_acc && !add_bad && !add_full;

  gtc_ram #(.WIDTH(2*NAW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(add_we), .waddr(edge_count_r[EAW-1:0]),
    .wdata({NAW'(end_a - 11'd1), NAW'(end_b - 11'd1)}),
    .raddr(idx_r), .rdata(edge_q)
  );

  assign ea = edge_q[2*NAW-1:NAW];
  assign eb = edge_q[NAW-1:0];

  // two copies of the marks so both endpoints are read in the same cycle
  assign mark   = cmd.relax && (va ^ vb);
  assign vis_we = cmd.clr || cmd.seed || mark;
  assign vis_wd = !cmd.clr;
  assign vis_wa = cmd.clr ? sweep_r : (cmd.seed ? '0 : (va ? eb : ea));

  gtc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis_a (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(ea), .rdata(va)
  );
  gtc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis_b (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(eb), .rdata(vb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      error_r <= 1'b0;
      sweep_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (add_we) edge_count_r <= edge_count_r + 1'b1;
      if (add_acc && (add_bad || add_full)) error_r <= 1'b1;
      if (cmd.sweep_rst) begin
        sweep_r <= '0;
      end else if (cmd.clr) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        edge_count_r <= '0;
        error_r <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bad_r <= error_r || (n32 == 0) || (n32 > MAX_NODES);
    end else if (cmd.chk && ((32'(ea) >= n32) || (32'(eb) >= n32))) begin
      bad_r <= 1'b1;
    end
    if (cmd.start || cmd.seed || cmd.pass_rst) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.seed || cmd.pass_rst) begin
      changed_r <= 1'b0;
    end else if (mark) begin
      changed_r <= 1'b1;
    end
    if (cmd.seed) begin
      vcnt_r <= VW'(1);
    end else if (mark) begin
      vcnt_r <= vcnt_r + 1'b1;
    end
    if (cmd.finish) begin
      out_tree_r <= !bad_r && sts.cnt_ok && (32'(vcnt_r) == n32);
      out_bad_r <= bad_r;
    end
  end

  assign sts.fin_acc    = fin_acc;
  assign sts.cnt_zero   = (edge_count_r == '0);
  assign sts.idx_last   = (32'(idx_r) + 32'd1 == 32'(edge_count_r));
  assign sts.sweep_last = (32'(sweep_r) == MAX_NODES - 1);
  assign sts.bad        = bad_r;
  assign sts.cnt_ok     = (32'(edge_count_r) + 32'd1 == n32);
  assign sts.changed    = changed_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_is_tree   = out_tree_r;
  assign out_bad_input = out_bad_r;

endmodule

// ===== src/graph_tree_check_top.sv =====
// ----------------------------------------------------------------------------
// graph_tree_check_top
// checks whether a loaded undirected graph on node_count nodes is a tree
// ----------------------------------------------------------------------------
// usage:
//   set node_count over the apb port (byte address 0) while the block is idle
//   send edge beats (in_req_type add) with 1-based endpoints; edge beats
//   produce no result
//   a finish beat produces one result beat: is_tree and bad_input
// after the accepting edge of a finish, an endpoint check pass reads each
//   stored edge; then the walk (skipped when the edge count or the check
//   already rules out a tree) marks the first node and runs reachability
//   passes until one marks no new node; then the result is loaded. The
//   number of passes is at most node_count and is set by how far marks
//   spread through the edge order in one pass of the edge ram
// after each finish, and after reset, a clear pass wipes all MAX_NODES
//   visited marks; in_stall is high during it and during the walk
// a result waiting under out_stall holds; edge beats are still accepted, and
//   a later finish waits at its end until the result register is free
// ----------------------------------------------------------------------------
module graph_tree_check_top #(
  parameter int MAX_NODES = gtc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = gtc_pkg::DEF_MAX_EDGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [gtc_pkg::NODE_W-1:0]  in_end_a,
  input  logic [gtc_pkg::NODE_W-1:0]  in_end_b,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_tree,
  output logic                        out_bad_input,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtc_pkg::PADDR_W-1:0] paddr,
  input  logic [gtc_pkg::PDATA_W-1:0] pwdata,
  output logic [gtc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [gtc_pkg::NODE_W-1:0] node_count_r;
  logic                       busy, in_acc;
  gtc_pkg::gtc_cmd_t          cmd;
  gtc_pkg::gtc_sts_t          sts;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= gtc_pkg::NODE_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == gtc_pkg::REG_NODE_COUNT)) begin
      node_count_r <= pwdata[gtc_pkg::NODE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == gtc_pkg::REG_NODE_COUNT) ?
                  gtc_pkg::PDATA_W'(node_count_r) : '0;

  // beats are only taken while the sequencer sits idle
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;

  gtc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd), .busy(busy)
  );

  gtc_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .add_acc(in_acc && (in_req_type == gtc_pkg::REQ_ADD)),
    .fin_acc(in_acc && (in_req_type == gtc_pkg::REQ_FINISH)),
    .end_a(in_end_a), .end_b(in_end_b), .node_count(node_count_r),
    .cmd(cmd), .out_stall(out_stall), .sts(sts),
    .out_valid(out_valid), .out_is_tree(out_is_tree), .out_bad_input(out_bad_input)
  );

  // a tree answer never comes with the error flag
  a_tree_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_tree && out_bad_input))
    else $error("tree answer with bad input");

  // a new result is only loaded while inputs are held off
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> in_stall)
    else $error("result loaded while accepting beats");

  // the clear pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("beats accepted before clear pass");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.finish)
    else $error("result overwritten under stall");

endmodule
